FILE: design/irpwbt_pkg.sv
// ----------------------------------------------------------------------------
// irpwbt_pkg
// Shared types and constants of the IR pulse width byte transmitter.
// ----------------------------------------------------------------------------
package irpwbt_pkg;

    localparam int CYC_W    = 10;   // carrier cycle count fields
    localparam int GAP_W    = 8;    // gap tick field
    localparam int PAUSE_W  = 16;   // end pause tick field
    localparam int CNT_W    = 16;   // segment tick counter
    localparam int BYTE_W   = 8;    // transmitted byte
    localparam int OUT_W    = 8;    // result tdata, four flags padded to a byte
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // input kind carried on s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register word index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_HEADER = 3'd0,
        REG_ONE    = 3'd1,
        REG_ZERO   = 3'd2,
        REG_GAP    = 3'd3,
        REG_PAUSE  = 3'd4
    } reg_idx_t;

    localparam logic [CYC_W-1:0]   RST_HEADER = CYC_W'(92);
    localparam logic [CYC_W-1:0]   RST_ONE    = CYC_W'(46);
    localparam logic [CYC_W-1:0]   RST_ZERO   = CYC_W'(23);
    localparam logic [GAP_W-1:0]   RST_GAP    = GAP_W'(20);
    localparam logic [PAUSE_W-1:0] RST_PAUSE  = PAUSE_W'(385);

    typedef struct packed {
        logic [CYC_W-1:0]   header_cycles;
        logic [CYC_W-1:0]   one_cycles;
        logic [CYC_W-1:0]   zero_cycles;
        logic [GAP_W-1:0]   gap_ticks;
        logic [PAUSE_W-1:0] end_pause_ticks;
    } cfg_t;

endpackage

FILE: design/irpwbt_cfg.sv
// ----------------------------------------------------------------------------
// irpwbt_cfg
// APB register file holding the frame timing settings.
// ----------------------------------------------------------------------------
module irpwbt_cfg
    import irpwbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_cycles   <= RST_HEADER;
            cfg_reg.one_cycles      <= RST_ONE;
            cfg_reg.zero_cycles     <= RST_ZERO;
            cfg_reg.gap_ticks       <= RST_GAP;
            cfg_reg.end_pause_ticks <= RST_PAUSE;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_HEADER: cfg_reg.header_cycles   <= pwdata[CYC_W-1:0];
                REG_ONE:    cfg_reg.one_cycles      <= pwdata[CYC_W-1:0];
                REG_ZERO:   cfg_reg.zero_cycles     <= pwdata[CYC_W-1:0];
                REG_GAP:    cfg_reg.gap_ticks       <= pwdata[GAP_W-1:0];
                REG_PAUSE:  cfg_reg.end_pause_ticks <= pwdata[PAUSE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (widx)
            REG_HEADER: prdata = APB_DW'(cfg_reg.header_cycles);
            REG_ONE:    prdata = APB_DW'(cfg_reg.one_cycles);
            REG_ZERO:   prdata = APB_DW'(cfg_reg.zero_cycles);
            REG_GAP:    prdata = APB_DW'(cfg_reg.gap_ticks);
            REG_PAUSE:  prdata = APB_DW'(cfg_reg.end_pause_ticks);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: design/ir_pulse_width_byte_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_byte_transmitter
// Tick-paced IR byte transmitter: header burst, LSB-first bit bursts, silent
// header, end pause; one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Every input transaction (a load or one half-carrier tick) gives exactly one
// result transaction. The block takes one transaction per clock: an input
// register holds the item, the segment sequencer updates in the same cycle it
// drains that register into the result register, and the sustained rate is one
// transaction per clock as long as m_tready stays high. Empty segments (zero
// carrier cycles, zero gap, zero pause) are skipped inside that single pass;
// with a zero gap, runs of empty bit bursts are found by a priority search over
// the remaining bit positions. A load while a frame or its end pause is running
// is dropped and flagged. Timing registers are written over APB and should only
// change while no frame is in progress.
// ----------------------------------------------------------------------------
module ir_pulse_width_byte_transmitter
    import irpwbt_pkg::*;
#(
    parameter int BITS_PER_FRAME = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] op: 0 load byte, 1 tick
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [0] ir_level [1] busy_res
                                         // [2] frame_done [3] request_dropped
                                         // [7:4] zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(BITS_PER_FRAME + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_HDR_GAP,
        PH_BIT,
        PH_BIT_GAP,
        PH_SIL,
        PH_SIL_GAP,
        PH_PAUSE
    } phase_t;

    // where the sequencer lands after entering a segment
    typedef struct packed {
        phase_t            phase;
        logic [BYTE_W-1:0] shift;
        logic [IDX_W-1:0]  idx;
    } seg_t;

    cfg_t cfg;

    irpwbt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Closing segments: silent header, its gap, end pause, then idle.
    function automatic phase_t enter_tail(phase_t p, cfg_t c);
        phase_t r;
        r = PH_IDLE;
        priority if (p == PH_SIL && c.header_cycles != '0)
            r = PH_SIL;
        else if ((p == PH_SIL || p == PH_SIL_GAP) && c.gap_ticks != '0)
            r = PH_SIL_GAP;
        else if (c.end_pause_ticks != '0)
            r = PH_PAUSE;
        else
            r = PH_IDLE;
        return r;
    endfunction

    // Enter the bit burst at position idx with the byte shifted so far.
    function automatic seg_t enter_bit(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] shift,
                                       cfg_t c);
        seg_t              r;
        logic              found;
        logic [BYTE_W-1:0] s_k;
        logic              nz;
        r.phase = enter_tail(PH_SIL, c);
        r.shift = shift;
        r.idx   = idx;
        found   = 1'b0;
        if (int'(idx) < BITS_PER_FRAME)
        begin
            if (c.gap_ticks != '0)
            begin
                nz      = shift[0] ? (c.one_cycles != '0) : (c.zero_cycles != '0);
                r.phase = nz ? PH_BIT : PH_BIT_GAP;
            end
            else
            begin
                // no gaps: first non-empty burst among the remaining bits
                for (int k = 0; k < BITS_PER_FRAME; k++)
                begin
                    s_k = shift >> k;
                    nz  = s_k[0] ? (c.one_cycles != '0) : (c.zero_cycles != '0);
                    if (!found && (int'(idx) + k < BITS_PER_FRAME) && nz)
                    begin
                        found   = 1'b1;
                        r.phase = PH_BIT;
                        r.shift = s_k;
                        r.idx   = idx + IDX_W'(k);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] seg_count(seg_t r, cfg_t c);
        logic [CNT_W-1:0] n;
        n = '0;
        unique case (r.phase)
            PH_HDR, PH_SIL:
                n = {5'b0, c.header_cycles, 1'b0};
            PH_BIT:
                n = {5'b0, (r.shift[0] ? c.one_cycles : c.zero_cycles), 1'b0};
            PH_HDR_GAP, PH_BIT_GAP, PH_SIL_GAP:
                n = {8'b0, c.gap_ticks};
            PH_PAUSE:
                n = c.end_pause_ticks;
            PH_IDLE:
                n = '0;
            default:
                n = '0;
        endcase
        return n;
    endfunction

    // input register
    logic              item_valid_reg, item_valid_next;
    logic              item_op_reg, item_op_next;
    logic [BYTE_W-1:0] item_data_reg, item_data_next;

    // sequencer state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              half_reg, half_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic              fire;
    logic              take;
    logic              lvl, busy, done, dropped;
    logic              enter_en;
    seg_t              seg;
    logic [BYTE_W-1:0] shift_dn;
    logic [IDX_W-1:0]  idx_up;

    assign fire     = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || fire;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign shift_dn = shift_reg >> 1;
    assign idx_up   = idx_reg + IDX_W'(1);

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_op_next    = item_op_reg;
        item_data_next  = item_data_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
            item_op_next    = s_tuser;
            item_data_next  = s_tdata;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end

        phase_next = phase_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        half_next  = half_reg;
        lvl        = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        dropped    = 1'b0;
        enter_en   = 1'b0;
        seg        = '{phase: PH_IDLE, shift: shift_reg, idx: idx_reg};

        if (fire)
        begin
            if (item_op_reg == OP_LOAD)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    dropped = 1'b1;
                    busy    = 1'b1;
                end
                else
                begin
                    enter_en = 1'b1;
                    priority if (cfg.header_cycles != '0)
                        seg = '{phase: PH_HDR, shift: item_data_reg, idx: '0};
                    else if (cfg.gap_ticks != '0)
                        seg = '{phase: PH_HDR_GAP, shift: item_data_reg, idx: '0};
                    else
                        seg = enter_bit('0, item_data_reg, cfg);
                    busy = (seg.phase != PH_IDLE);
                    done = !busy;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                busy       = 1'b1;
                lvl        = (phase_reg == PH_HDR || phase_reg == PH_BIT) && !half_reg;
                half_next  = !half_reg;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    enter_en = 1'b1;
                    unique case (phase_reg)
                        PH_HDR:
                            if (cfg.gap_ticks != '0)
                                seg = '{phase: PH_HDR_GAP, shift: shift_reg, idx: idx_reg};
                            else
                                seg = enter_bit('0, shift_reg, cfg);
                        PH_HDR_GAP:
                            seg = enter_bit('0, shift_reg, cfg);
                        PH_BIT:
                            if (cfg.gap_ticks != '0)
                                seg = '{phase: PH_BIT_GAP, shift: shift_reg, idx: idx_reg};
                            else
                                seg = enter_bit(idx_up, shift_dn, cfg);
                        PH_BIT_GAP:
                            seg = enter_bit(idx_up, shift_dn, cfg);
                        PH_SIL:
                            seg.phase = enter_tail(PH_SIL_GAP, cfg);
                        PH_SIL_GAP:
                            seg.phase = enter_tail(PH_PAUSE, cfg);
                        PH_PAUSE:
                            seg.phase = PH_IDLE;
                        PH_IDLE:
                            seg.phase = PH_IDLE;
                        default:
                            seg.phase = PH_IDLE;
                    endcase
                    done = (seg.phase == PH_IDLE);
                end
            end
        end

        if (enter_en)
        begin
            phase_next = seg.phase;
            shift_next = seg.shift;
            idx_next   = seg.idx;
            count_next = seg_count(seg, cfg);
            half_next  = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, dropped, done, busy, lvl};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            shift_reg      <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            half_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            half_reg       <= half_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        item_op_reg   <= item_op_next;
        item_data_reg <= item_data_next;
        out_data_reg  <= out_data_next;
    end

endmodule
